// ----- src/bdq_pkg.sv -----
package bdq_pkg;

  localparam int CAPACITY_DEF = 64;

  localparam int OPC_W  = 4;
  localparam int WORD_W = 32;
  localparam int POS_W  = 7;
  localparam int STS_W  = 2;
  localparam int OCC_W  = 7;

  localparam logic [OPC_W-1:0] OP_PUSH_BACK  = 4'd0;
  localparam logic [OPC_W-1:0] OP_PUSH_FRONT = 4'd1;
  localparam logic [OPC_W-1:0] OP_POP_BACK   = 4'd2;
  localparam logic [OPC_W-1:0] OP_POP_FRONT  = 4'd3;
  localparam logic [OPC_W-1:0] OP_READ       = 4'd4;
  localparam logic [OPC_W-1:0] OP_WRITE      = 4'd5;
  localparam logic [OPC_W-1:0] OP_INSERT     = 4'd6;
  localparam logic [OPC_W-1:0] OP_ERASE      = 4'd7;
  localparam logic [OPC_W-1:0] OP_CLEAR      = 4'd8;

  localparam logic [STS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STS_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STS_W-1:0] ST_RANGE = 2'd3;

  // what every cell of the chain does
  localparam logic [1:0] CM_HOLD   = 2'd0;
  localparam logic [1:0] CM_LOAD   = 2'd1;
  localparam logic [1:0] CM_INSERT = 2'd2;
  localparam logic [1:0] CM_REMOVE = 2'd3;

  typedef struct packed {
    logic [OPC_W-1:0]         opcode;
    logic signed [WORD_W-1:0] word_in;
    logic [POS_W-1:0]         position;
  } in_word_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] word_out;
    logic [STS_W-1:0]         status;
    logic [OCC_W-1:0]         occupancy;
    logic signed [WORD_W-1:0] first_word;
    logic signed [WORD_W-1:0] last_word;
  } out_word_t;

  typedef struct packed {
    logic [1:0]               mode;
    logic signed [WORD_W-1:0] word;
  } cell_ctl_t;

endpackage

// ----- src/bdq_cell.sv -----
module bdq_cell #(
  parameter int IDX = 0,
  parameter int KW  = 6
) (
  input  logic                              clk,
  input  bdq_pkg::cell_ctl_t                ctl,
  input  logic [KW-1:0]                     at,
  input  logic signed [bdq_pkg::WORD_W-1:0] left_word,
  input  logic signed [bdq_pkg::WORD_W-1:0] right_word,
  output logic signed [bdq_pkg::WORD_W-1:0] word_q
);

  localparam logic [KW-1:0] MY_IDX = KW'(IDX);

  logic signed [bdq_pkg::WORD_W-1:0] word_r;
  logic signed [bdq_pkg::WORD_W-1:0] word_nxt;

  always_comb begin
    word_nxt = word_r;
    unique case (ctl.mode)
      bdq_pkg::CM_HOLD: begin
        word_nxt = word_r;
      end
      bdq_pkg::CM_LOAD: begin
        if (MY_IDX == at) word_nxt = ctl.word;
      end
      bdq_pkg::CM_INSERT: begin
        // cells past the gap take their left neighbor
        if (MY_IDX == at) word_nxt = ctl.word;
        else if (MY_IDX > at) word_nxt = left_word;
      end
      bdq_pkg::CM_REMOVE: begin
        if (MY_IDX >= at) word_nxt = right_word;
      end
      default: word_nxt = word_r;
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word_q = word_r;

endmodule

// ----- src/bounded_deque_with_positional_edit_top.sv -----
// Bounded double-ended queue of signed 32-bit words held in a row of CAPACITY
// cells, with push and pop at either end, read and write at a position,
// insert before a position, erase at a position and clear. The block accepts
// a new word every cycle unless the input is stalled: insert and erase shift
// all later cells toward or away from the gap as the word is accepted, since
// each cell loads from its neighbor. The result word is ready in the cycle
// after acceptance and sits in an output register; the input is stalled
// only while that register holds a word that the receiver stalls.
// The first and last words of a result are read from the cells, which do not
// change until the next word is accepted.
module bounded_deque_with_positional_edit_top #(
  parameter int CAPACITY = bdq_pkg::CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  bdq_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output bdq_pkg::out_word_t out_word
);

  localparam int KW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > bdq_pkg::POS_W) ? CW : bdq_pkg::POS_W;
  localparam logic [CW-1:0] CNT_FULL = CW'(CAPACITY);

  logic signed [bdq_pkg::WORD_W-1:0] cell_word [CAPACITY];

  logic [CW-1:0]                     count_r;
  logic [CW-1:0]                     count_nxt;
  logic                              out_valid_r;
  logic signed [bdq_pkg::WORD_W-1:0] res_word_r;
  logic signed [bdq_pkg::WORD_W-1:0] res_word_nxt;
  logic [bdq_pkg::STS_W-1:0]         res_status_r;
  logic [bdq_pkg::STS_W-1:0]         res_status_nxt;

  logic                              accept;
  logic                              full;
  logic                              empty;
  logic [PW-1:0]                     pos_ext;
  logic [PW-1:0]                     cnt_ext;
  logic                              pos_below;
  logic                              pos_upto;
  logic [1:0]                        mode;
  logic [KW-1:0]                     at;
  logic [KW-1:0]                     rd_idx;
  logic [KW-1:0]                     last_idx;
  logic signed [bdq_pkg::WORD_W-1:0] rd_word;
  bdq_pkg::cell_ctl_t                ctl;

  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  assign full      = (count_r == CNT_FULL);
  assign empty     = (count_r == '0);
  assign pos_ext   = PW'(in_word.position);
  assign cnt_ext   = PW'(count_r);
  assign pos_below = (pos_ext < cnt_ext);
  assign pos_upto  = (pos_ext <= cnt_ext);

  assign last_idx = KW'(count_r - CW'(1));
  assign rd_idx   = (in_word.opcode == bdq_pkg::OP_POP_BACK) ? last_idx
                  : (in_word.opcode == bdq_pkg::OP_POP_FRONT) ? '0
                  : KW'(in_word.position);
  assign rd_word  = cell_word[rd_idx];

  always_comb begin
    mode           = bdq_pkg::CM_HOLD;
    at             = '0;
    count_nxt      = count_r;
    res_word_nxt   = '0;
    res_status_nxt = bdq_pkg::ST_OK;
    unique case (in_word.opcode)
      bdq_pkg::OP_PUSH_BACK: begin
        if (full) begin
          res_status_nxt = bdq_pkg::ST_FULL;
        end else begin
          mode      = bdq_pkg::CM_LOAD;
          at        = KW'(count_r);
          count_nxt = count_r + CW'(1);
        end
      end
      bdq_pkg::OP_PUSH_FRONT: begin
        if (full) begin
          res_status_nxt = bdq_pkg::ST_FULL;
        end else begin
          mode      = bdq_pkg::CM_INSERT;
          count_nxt = count_r + CW'(1);
        end
      end
      bdq_pkg::OP_POP_BACK: begin
        if (empty) begin
          res_word_nxt   = '1;
          res_status_nxt = bdq_pkg::ST_EMPTY;
        end else begin
          res_word_nxt = rd_word;
          count_nxt    = count_r - CW'(1);
        end
      end
      bdq_pkg::OP_POP_FRONT: begin
        if (empty) begin
          res_word_nxt   = '1;
          res_status_nxt = bdq_pkg::ST_EMPTY;
        end else begin
          res_word_nxt = rd_word;
          mode         = bdq_pkg::CM_REMOVE;
          count_nxt    = count_r - CW'(1);
        end
      end
      bdq_pkg::OP_READ: begin
        if (!pos_below) res_status_nxt = bdq_pkg::ST_RANGE;
        else res_word_nxt = rd_word;
      end
      bdq_pkg::OP_WRITE: begin
        if (!pos_below) begin
          res_status_nxt = bdq_pkg::ST_RANGE;
        end else begin
          mode = bdq_pkg::CM_LOAD;
          at   = KW'(in_word.position);
        end
      end
      bdq_pkg::OP_INSERT: begin
        // range is checked before fullness
        if (!pos_upto) begin
          res_status_nxt = bdq_pkg::ST_RANGE;
        end else if (full) begin
          res_status_nxt = bdq_pkg::ST_FULL;
        end else begin
          mode      = bdq_pkg::CM_INSERT;
          at        = KW'(in_word.position);
          count_nxt = count_r + CW'(1);
        end
      end
      bdq_pkg::OP_ERASE: begin
        if (!pos_below) begin
          res_status_nxt = bdq_pkg::ST_RANGE;
        end else begin
          mode      = bdq_pkg::CM_REMOVE;
          at        = KW'(in_word.position);
          count_nxt = count_r - CW'(1);
        end
      end
      bdq_pkg::OP_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
        mode = bdq_pkg::CM_HOLD;
      end
    endcase
  end

  assign ctl.mode = accept ? mode : bdq_pkg::CM_HOLD;
  assign ctl.word = in_word.word_in;

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic signed [bdq_pkg::WORD_W-1:0] left_w;
    logic signed [bdq_pkg::WORD_W-1:0] right_w;
    if (k == 0) begin : g_head
      assign left_w = '0;
    end else begin : g_body
      assign left_w = cell_word[k-1];
    end
    // the tail cell keeps its own word on a remove
    if (k == CAPACITY - 1) begin : g_tail
      assign right_w = cell_word[k];
    end else begin : g_mid
      assign right_w = cell_word[k+1];
    end
    bdq_cell #(
      .IDX (k),
      .KW  (KW)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .at         (at),
      .left_word  (left_w),
      .right_word (right_w),
      .word_q     (cell_word[k])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_word_r   <= res_word_nxt;
      res_status_r <= res_status_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_word.word_out   = res_word_r;
  assign out_word.status     = res_status_r;
  assign out_word.occupancy  = bdq_pkg::OCC_W'(count_r);
  assign out_word.first_word = empty ? '0 : cell_word[0];
  assign out_word.last_word  = empty ? '0 : cell_word[last_idx];

endmodule

// ----- src/bdq_checker.sv -----
module bdq_checker #(
  parameter int CAPACITY = bdq_pkg::CAPACITY_DEF
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input bdq_pkg::out_word_t out_word,
  input logic               out_valid,
  input logic               out_stall
);

  // an accepted word always yields a result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted word produced no result");

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_word.occupancy) <= CAPACITY))
    else $error("occupancy beyond capacity");

  a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.occupancy == '0 |->
      out_word.first_word == '0 && out_word.last_word == '0)
    else $error("end words not zero on empty queue");

  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.status == bdq_pkg::ST_EMPTY |->
      out_word.word_out == '1 && out_word.occupancy == '0)
    else $error("empty pop result malformed");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled result changed");

endmodule

bind bounded_deque_with_positional_edit_top bdq_checker #(
  .CAPACITY (CAPACITY)
) u_bdq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_word  (out_word),
  .out_valid (out_valid),
  .out_stall (out_stall)
);
